@@ src/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // Configuration register indexes.
    localparam logic CFG_TERMINATOR = 1'b0;
    localparam logic CFG_ALLOWED    = 1'b1;

    // Terminator modes.
    localparam logic [1:0] TERM_DQUOTE = 2'd0;
    localparam logic [1:0] TERM_SQUOTE = 2'd1;
    localparam logic [1:0] TERM_SLASH  = 2'd2;
    localparam logic [1:0] TERM_NONE   = 2'd3;

    // Allowed byte classes. The spare code accepts any byte.
    localparam logic [1:0] ALLOW_ANY   = 2'd0;
    localparam logic [1:0] ALLOW_REGEX = 2'd1;
    localparam logic [1:0] ALLOW_IDENT = 2'd2;
    localparam logic [1:0] ALLOW_SPARE = 2'd3;

    // Escape phases.
    localparam logic [1:0] PH_NORMAL  = 2'd0;
    localparam logic [1:0] PH_ESCAPE  = 2'd1;
    localparam logic [1:0] PH_UNICODE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_DATA       = 3'd0;
    localparam logic [2:0] ST_TERM       = 3'd1;
    localparam logic [2:0] ST_DISALLOWED = 3'd2;
    localparam logic [2:0] ST_CONTROL    = 3'd3;
    localparam logic [2:0] ST_HEXESC     = 3'd4;
    localparam logic [2:0] ST_OCTAL      = 3'd5;
    localparam logic [2:0] ST_BADUNI     = 3'd6;
    localparam logic [2:0] ST_EARLYEND   = 3'd7;

    // Character codes.
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CTRL_MAX  = 8'h1F;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_VTAB      = 8'h0B;

    // Queue between the decoder and the output serializer.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One decoded group: up to three result bytes from a single input beat.
    typedef struct packed {
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [2:0] status;
        logic [1:0] cnt;
    } pkt_t;

    // Hex digit value; bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = {1'b0, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Terminator match for the configured mode. A zero byte never matches.
    function automatic logic is_terminator(input logic [1:0] mode, input logic [7:0] b);
        logic r;
        unique case (mode)
            TERM_DQUOTE: r = (b == CH_DQUOTE);
            TERM_SQUOTE: r = (b == CH_SQUOTE);
            TERM_SLASH:  r = (b == CH_SLASH);
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    // Allowed byte class check; the unused mode acts as any.
    function automatic logic is_allowed(input logic [1:0] mode, input logic [7:0] b);
        logic r;
        unique case (mode)
            ALLOW_REGEX: r = (b == 8'h67) || (b == 8'h69) || (b == 8'h6D) || (b == 8'h73);
            ALLOW_IDENT: r = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                             (b >= 8'h30 && b <= 8'h39) || (b == 8'h5F) || (b == 8'h24);
            default:     r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Decoder front end: holds the escape state and the configuration, classifies
// each accepted input beat and builds a group of up to three result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire               cfg_addr,
    input  wire  [1:0]        cfg_wdata,
    input  wire               in_accept,
    input  wire  [7:0]        in_byte,
    input  wire               in_end,
    output logic              push,
    output jsu_pkg::pkt_t     pkt
);

    logic [1:0]  term_mode_reg;
    logic [1:0]  allow_mode_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  digits_reg, digits_next;
    logic [11:0] acc_reg, acc_next;

    logic [4:0]  hex_d;
    logic [15:0] cp;
    logic [7:0]  cp_hi;
    logic [7:0]  cp_lo;
    logic        clear;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_mode_reg  <= jsu_pkg::TERM_DQUOTE;
            allow_mode_reg <= jsu_pkg::ALLOW_ANY;
        end else if (cfg_wr_en) begin
            if (cfg_addr == jsu_pkg::CFG_TERMINATOR) begin
                term_mode_reg <= cfg_wdata;
            end else begin
                allow_mode_reg <= cfg_wdata;
            end
        end
    end

    assign hex_d = jsu_pkg::hex_value(in_byte);
    assign cp    = {acc_reg, hex_d[3:0]};
    assign cp_hi = cp[15:8];
    assign cp_lo = cp[7:0];

    // Classify the beat and build its result group.
    always_comb begin
        pkt         = '0;
        pkt.status  = jsu_pkg::ST_DATA;
        phase_next  = phase_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        clear       = 1'b0;

        if (in_end) begin
            pkt.status = jsu_pkg::ST_EARLYEND;
            pkt.cnt    = 2'd1;
            clear      = 1'b1;
        end else begin
            unique case (phase_reg)
                jsu_pkg::PH_UNICODE: begin
                    if (hex_d[4]) begin
                        pkt.status = jsu_pkg::ST_BADUNI;
                        pkt.cnt    = 2'd1;
                        clear      = 1'b1;
                    end else if (digits_reg != 2'd3) begin
                        acc_next    = {acc_reg[7:0], hex_d[3:0]};
                        digits_next = digits_reg + 2'd1;
                    end else begin
                        // Fourth digit: encode the code point as UTF-8.
                        clear = 1'b1;
                        if (cp_hi == 8'h00 && !cp_lo[7]) begin
                            pkt.data0 = cp_lo;
                            pkt.cnt   = 2'd1;
                        end else if (cp_hi < 8'h08) begin
                            pkt.data0 = {3'b110, cp_hi[2:0], cp_lo[7:6]};
                            pkt.data1 = {2'b10, cp_lo[5:0]};
                            pkt.cnt   = 2'd2;
                        end else begin
                            pkt.data0 = {4'b1110, cp_hi[7:4]};
                            pkt.data1 = {2'b10, cp_hi[3:0], cp_lo[7:6]};
                            pkt.data2 = {2'b10, cp_lo[5:0]};
                            pkt.cnt   = 2'd3;
                        end
                    end
                end
                jsu_pkg::PH_ESCAPE: begin
                    phase_next = jsu_pkg::PH_NORMAL;
                    pkt.cnt    = 2'd1;
                    unique case (in_byte) inside
                        jsu_pkg::CH_LOWER_B: pkt.data0 = jsu_pkg::CH_BACKSPACE;
                        jsu_pkg::CH_LOWER_F: pkt.data0 = jsu_pkg::CH_FORMFEED;
                        jsu_pkg::CH_LOWER_N: pkt.data0 = jsu_pkg::CH_NEWLINE;
                        jsu_pkg::CH_LOWER_R: pkt.data0 = jsu_pkg::CH_RETURN;
                        jsu_pkg::CH_LOWER_T: pkt.data0 = jsu_pkg::CH_TAB;
                        jsu_pkg::CH_LOWER_V: pkt.data0 = jsu_pkg::CH_VTAB;
                        jsu_pkg::CH_LOWER_U: begin
                            phase_next  = jsu_pkg::PH_UNICODE;
                            digits_next = 2'd0;
                            acc_next    = '0;
                            pkt.cnt     = 2'd0;
                        end
                        jsu_pkg::CH_LOWER_X: begin
                            pkt.status = jsu_pkg::ST_HEXESC;
                            clear      = 1'b1;
                        end
                        [8'h30:8'h37]: begin
                            pkt.status = jsu_pkg::ST_OCTAL;
                            clear      = 1'b1;
                        end
                        default: pkt.data0 = in_byte;
                    endcase
                end
                default: begin
                    // Normal phase; the unused phase code behaves the same.
                    phase_next = jsu_pkg::PH_NORMAL;
                    pkt.cnt    = 2'd1;
                    if (jsu_pkg::is_terminator(term_mode_reg, in_byte)) begin
                        pkt.data0  = in_byte;
                        pkt.status = jsu_pkg::ST_TERM;
                        clear      = 1'b1;
                    end else if (!jsu_pkg::is_allowed(allow_mode_reg, in_byte)) begin
                        pkt.data0  = in_byte;
                        pkt.status = jsu_pkg::ST_DISALLOWED;
                        clear      = 1'b1;
                    end else if (in_byte <= jsu_pkg::CH_CTRL_MAX) begin
                        pkt.status = jsu_pkg::ST_CONTROL;
                        clear      = 1'b1;
                    end else if (in_byte == jsu_pkg::CH_BACKSLASH) begin
                        phase_next = jsu_pkg::PH_ESCAPE;
                        pkt.cnt    = 2'd0;
                    end else begin
                        pkt.data0 = in_byte;
                    end
                end
            endcase
        end

        if (clear) begin
            phase_next  = jsu_pkg::PH_NORMAL;
            digits_next = '0;
            acc_next    = '0;
        end
    end

    assign push = in_accept && (pkt.cnt != 2'd0);

    // Escape state advances on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= jsu_pkg::PH_NORMAL;
            digits_reg <= '0;
            acc_reg    <= '0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

`default_nettype wire

@@ src/jsu_fifo.sv @@
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of decoded result groups between the front end and the output
// serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  jsu_pkg::pkt_t     wr_pkt,
    input  wire               pop,
    output jsu_pkg::pkt_t     rd_pkt,
    output logic              full,
    output logic              empty
);

    jsu_pkg::pkt_t                mem [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [jsu_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [jsu_pkg::FIFO_AW:0]    count_reg, count_next;

    assign full   = (count_reg == (jsu_pkg::FIFO_AW+1)'(jsu_pkg::FIFO_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_pkt = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_pkt;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: takes result groups from the queue and sends them one
// beat per byte through a registered output stage, marking the final beat.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
    input  wire               aclk,
    input  wire               aresetn,
    input  jsu_pkg::pkt_t     head,
    input  wire               empty,
    output logic              pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [7:0]        m_tdata,    // out_byte[7:0]
    output logic [2:0]        m_tuser,    // status[2:0]
    output logic              m_tlast
);

    logic [1:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic [2:0] m_tuser_reg;
    logic       m_tlast_reg;
    logic       load;
    logic       is_last;
    logic [7:0] beat_byte;

    assign load    = !empty && (!m_tvalid_reg || m_tready);
    assign is_last = (idx_reg == (head.cnt - 2'd1));
    assign pop     = load && is_last;

    // Pick the byte of the group for this beat.
    always_comb begin
        case (idx_reg)
            2'd0:    beat_byte = head.data0;
            2'd1:    beat_byte = head.data1;
            default: beat_byte = head.data2;
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            idx_next      = is_last ? 2'd0 : idx_reg + 2'd1;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= beat_byte;
            m_tuser_reg <= head.status;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // While the queue holds a group, the beat index stays inside the group at its head.
    a_idx_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> (head.cnt != 2'd0) && (idx_reg < head.cnt))
        else $error("beat index outside the queued group");

    // A stop or error status is a single result and so always the final beat.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != jsu_pkg::ST_DATA) |-> m_tlast)
        else $error("stop or error beat not marked last");

    // A group leaves the queue exactly when its final beat is loaded.
    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid && m_tlast)
        else $error("group popped without a final beat");

    // Beats within a multi-byte group are not marked last early.
    a_mid_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !is_last |=> m_tvalid && !m_tlast)
        else $error("middle beat of a group marked last");

endmodule

`default_nettype wire

@@ src/json_string_unescape.sv @@
// Result groups are queued and then registered at the output. Throughput: one
// input beat per cycle while the queue is not full; a \u escape gives up to
// three output beats, one per cycle unless stalled, set by the serializer. A
// four-entry group queue lets input run ahead while output is stalled. Reset
// (aresetn, synchronous, active low) clears the escape state, the queue, the
// output valid and both configuration registers; there is no clearing pass.
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for the body of a JSON-style string: backslash escapes,
// \u to UTF-8, terminator and allowed-class stops, and error reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape (
    input  wire        aclk,
    input  wire        aresetn,
    // Configuration write port.
    input  wire        cfg_wr_en,
    input  wire        cfg_addr,
    input  wire  [1:0] cfg_wdata,
    // Input stream.
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,    // in_byte[7:0]
    input  wire        s_tlast,    // is_end
    // Result stream.
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,    // out_byte[7:0]
    output logic [2:0] m_tuser,    // status[2:0]
    output logic       m_tlast     // last
);

    jsu_pkg::pkt_t front_pkt;
    jsu_pkg::pkt_t head_pkt;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    logic          in_accept;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    // Decoder front end.
    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .push      (push),
        .pkt       (front_pkt)
    );

    // Group queue.
    jsu_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_pkt  (front_pkt),
        .pop     (pop),
        .rd_pkt  (head_pkt),
        .full    (full),
        .empty   (empty)
    );

    // Output serializer.
    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_pkt),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
